// ----- hdl/sexl_pkg.sv -----
// types, codes and character classes for the s-expression lexer
package sexl_pkg;

  localparam int unsigned FifoDepth = 4;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_BOOL  = 4'd1,
    MODE_STR   = 4'd2,
    MODE_ESC   = 4'd3,
    MODE_CHAR1 = 4'd4,
    MODE_CHAR2 = 4'd5,
    MODE_INT   = 4'd6,
    MODE_FRAC  = 4'd7,
    MODE_SYM   = 4'd8,
    MODE_DROP  = 4'd9
  } mode_t;

  localparam logic [2:0] KIND_END    = 3'd0;
  localparam logic [2:0] KIND_OPEN   = 3'd1;
  localparam logic [2:0] KIND_CLOSE  = 3'd2;
  localparam logic [2:0] KIND_SYMBOL = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;
  localparam logic [2:0] KIND_CHAR   = 3'd5;
  localparam logic [2:0] KIND_NUMBER = 3'd6;
  localparam logic [2:0] KIND_BOOL   = 3'd7;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_START  = 3'd1;
  localparam logic [2:0] ERR_BAD_BOOL   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd4;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text;
    logic       cvalid;
    logic       tend;
    logic [2:0] err;
  } result_t;

  typedef struct packed {
    mode_t   mode;
    logic    has;
    result_t res;
  } idle_out_t;

  function automatic result_t mk(input logic [2:0] kind, input logic [7:0] ch,
                                 input logic cvalid, input logic tend,
                                 input logic [2:0] err);
    result_t r;
    r.kind   = kind;
    r.text   = ch;
    r.cvalid = cvalid;
    r.tend   = tend;
    r.err    = err;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic sym_start(input logic [7:0] c);
    return is_alpha(c) || c == CH_LT || c == CH_EQ || c == CH_GT || c == CH_UNDER ||
           c == CH_DOLLAR || c == CH_PCT || c == CH_BANG;
  endfunction

  function automatic logic sym_more(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_AT || c == CH_MINUS ||
           c == CH_UNDER || c == CH_PCT || c == CH_BANG || c == CH_COLON;
  endfunction

  // handling of a byte seen between tokens: at most one result
  function automatic idle_out_t idle_step(input logic [7:0] c);
    idle_out_t o;
    o.mode = MODE_IDLE;
    o.has  = 1'b1;
    o.res  = mk(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    if (c == CH_NUL) begin
      o.res = mk(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_LPAREN) begin
      o.res = mk(KIND_OPEN, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_RPAREN) begin
      o.res = mk(KIND_CLOSE, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
      o.has = 1'b0;
    end else if (c == CH_HASH) begin
      o.has  = 1'b0;
      o.mode = MODE_BOOL;
    end else if (c == CH_DQUOTE) begin
      o.has  = 1'b0;
      o.mode = MODE_STR;
    end else if (c == CH_SQUOTE) begin
      o.has  = 1'b0;
      o.mode = MODE_CHAR1;
    end else if (is_digit(c) || c == CH_MINUS || c == CH_PLUS) begin
      o.mode = MODE_INT;
      o.res  = mk(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
    end else if (sym_start(c)) begin
      o.mode = MODE_SYM;
      o.res  = mk(KIND_SYMBOL, c, 1'b1, 1'b0, ERR_NONE);
    end else begin
      // bad start char, never zero here, so lexer drops until end of input
      o.mode = MODE_DROP;
      o.res  = mk(KIND_END, c, 1'b0, 1'b1, ERR_BAD_START);
    end
    return o;
  endfunction

endpackage

// ----- hdl/s_expression_lexer_core.sv -----
// streaming s-expression tokenizer, one byte in per cycle while in_ready is high
// The lexer takes one text byte per accepted word and decides all of that
// byte's results in the same cycle, from the byte and the mode and held-char
// registers, writing them into a four-word result queue that drives the out_
// ports. A byte gives zero, one or two results; in_ready is high whenever the
// queue holds two words or fewer, so with the output side ready the block
// takes one byte every cycle. Only a byte that both closes a number or symbol
// and yields a result of its own (or an error on a zero byte) puts two words
// in, and a run of those stalls the input while the queue drains one word
// per cycle. Results leave in the order the bytes came in. A zero byte
// ends the text and returns the lexer to idle; after an error, bytes are
// dropped until that zero byte.
module s_expression_lexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_input_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_char_valid,
  output logic       out_token_end,
  output logic [2:0] out_error_code
);
  import sexl_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  // lexer state
  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;

  // result queue
  result_t           fifo_r [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  // per-byte decode
  logic [7:0] c;
  result_t    res0, res1;
  logic [1:0] nres;
  idle_out_t  idl;
  logic       do_fail;
  logic [2:0] fail_kind, fail_err;
  logic       in_fire, out_fire;

  assign c        = in_input_byte;
  assign in_ready = (cnt_r <= CntW'(FifoDepth - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    res0      = mk(KIND_END, CH_NUL, 1'b0, 1'b0, ERR_NONE);
    res1      = mk(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    nres      = 2'd0;
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    do_fail   = 1'b0;
    fail_kind = KIND_END;
    fail_err  = ERR_NONE;
    idl       = idle_step(c);
    unique case (mode_r)
      MODE_BOOL: begin
        if (c == CH_LOW_T || c == CH_LOW_F) begin
          mode_nxt = MODE_IDLE;
          res0     = mk(KIND_BOOL, c, 1'b1, 1'b1, ERR_NONE);
          nres     = 2'd1;
        end else begin
          do_fail   = 1'b1;
          fail_kind = KIND_BOOL;
          fail_err  = ERR_BAD_BOOL;
        end
      end
      MODE_STR: begin
        if (c == CH_DQUOTE) begin
          mode_nxt = MODE_IDLE;
          res0     = mk(KIND_STRING, CH_NUL, 1'b0, 1'b1, ERR_NONE);
          nres     = 2'd1;
        end else if (c == CH_NUL) begin
          do_fail   = 1'b1;
          fail_kind = KIND_STRING;
          fail_err  = ERR_OPEN_STR;
        end else if (c == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          res0 = mk(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
          nres = 2'd1;
        end
      end
      MODE_ESC: begin
        // escapes resolve to the character they stand for
        mode_nxt = MODE_STR;
        nres     = 2'd1;
        if (c == CH_BSLASH || c == CH_DQUOTE) begin
          res0 = mk(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
        end else if (c == CH_LOW_N) begin
          res0 = mk(KIND_STRING, CH_LF, 1'b1, 1'b0, ERR_NONE);
        end else if (c == CH_LOW_T) begin
          res0 = mk(KIND_STRING, CH_TAB, 1'b1, 1'b0, ERR_NONE);
        end else if (c == CH_LOW_R) begin
          res0 = mk(KIND_STRING, CH_CR, 1'b1, 1'b0, ERR_NONE);
        end else begin
          nres      = 2'd0;
          do_fail   = 1'b1;
          fail_kind = KIND_STRING;
          fail_err  = ERR_BAD_ESCAPE;
        end
      end
      MODE_CHAR1: begin
        if (c == CH_NUL) begin
          do_fail   = 1'b1;
          fail_kind = KIND_CHAR;
          fail_err  = ERR_BAD_CHAR;
        end else begin
          held_nxt = c;
          mode_nxt = MODE_CHAR2;
        end
      end
      MODE_CHAR2: begin
        if (c == CH_SQUOTE) begin
          mode_nxt = MODE_IDLE;
          res0     = mk(KIND_CHAR, held_r, 1'b1, 1'b1, ERR_NONE);
          nres     = 2'd1;
        end else begin
          do_fail   = 1'b1;
          fail_kind = KIND_CHAR;
          fail_err  = ERR_BAD_CHAR;
        end
      end
      MODE_INT, MODE_FRAC, MODE_SYM: begin
        if (mode_r == MODE_SYM ? sym_more(c) : is_digit(c)) begin
          res0 = mk((mode_r == MODE_SYM) ? KIND_SYMBOL : KIND_NUMBER, c,
                    1'b1, 1'b0, ERR_NONE);
          nres = 2'd1;
        end else if (mode_r == MODE_INT && c == CH_DOT) begin
          mode_nxt = MODE_FRAC;
          res0     = mk(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
          nres     = 2'd1;
        end else begin
          // close the token, then read the same byte as between tokens
          res0     = mk((mode_r == MODE_SYM) ? KIND_SYMBOL : KIND_NUMBER, CH_NUL,
                        1'b0, 1'b1, ERR_NONE);
          res1     = idl.res;
          nres     = idl.has ? 2'd2 : 2'd1;
          mode_nxt = idl.mode;
        end
      end
      MODE_DROP: begin
        if (c == CH_NUL) begin
          mode_nxt = MODE_IDLE;
          res0     = mk(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
          nres     = 2'd1;
        end
      end
      default: begin
        // idle, and unused mode codes
        res0     = idl.res;
        nres     = {1'b0, idl.has};
        mode_nxt = idl.mode;
      end
    endcase

    // error word, plus an end word when the error came on a zero byte
    if (do_fail) begin
      res0 = mk(fail_kind, c, 1'b0, 1'b1, fail_err);
      if (c == CH_NUL) begin
        res1     = mk(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
        nres     = 2'd2;
        mode_nxt = MODE_IDLE;
      end else begin
        nres     = 2'd1;
        mode_nxt = MODE_DROP;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + CntW'(nres);
    end
    if (out_fire) begin
      cnt_nxt = cnt_nxt - CntW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      held_r   <= CH_NUL;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        mode_r   <= mode_nxt;
        held_r   <= held_nxt;
        wr_ptr_r <= wr_ptr_r + PtrW'(nres);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
    end
  end

  // queue storage, up to two words written per byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (nres != 2'd0) begin
        fifo_r[wr_ptr_r] <= res0;
      end
      if (nres == 2'd2) begin
        fifo_r[wr_ptr_r + PtrW'(1)] <= res1;
      end
    end
  end

  assign out_token_kind = fifo_r[rd_ptr_r].kind;
  assign out_text_char  = fifo_r[rd_ptr_r].text;
  assign out_char_valid = fifo_r[rd_ptr_r].cvalid;
  assign out_token_end  = fifo_r[rd_ptr_r].tend;
  assign out_error_code = fifo_r[rd_ptr_r].err;

endmodule

// ----- hdl/sexl_checker.sv -----
// port-level checks for the s-expression lexer, bound to the top level
module sexl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_input_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_token_kind,
  input logic [7:0] out_text_char,
  input logic       out_char_valid,
  input logic       out_token_end,
  input logic [2:0] out_error_code
);
  import sexl_pkg::*;

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_input_byte))
    else $error("input word changed while stalled");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_text_char) && $stable(out_char_valid) && $stable(out_token_end) &&
    $stable(out_error_code))
    else $error("result word changed while stalled");

  // error words close the token and carry no text character
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_token_end && !out_char_valid)
    else $error("error word malformed");

  // a clean end word is a bare closing word
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END && out_error_code == ERR_NONE
    |-> out_token_end && !out_char_valid && out_text_char == CH_NUL)
    else $error("end word malformed");

  // input only stalls behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no results pending");

endmodule

bind s_expression_lexer_core sexl_checker u_sexl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_input_byte  (in_input_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_token_kind (out_token_kind),
  .out_text_char  (out_text_char),
  .out_char_valid (out_char_valid),
  .out_token_end  (out_token_end),
  .out_error_code (out_error_code)
);

// ----- test/sexl_token_checker.sv -----
// token checker: predicts lexer results from accepted bytes and compares the result stream
`timescale 1ns / 100ps

module sexl_token_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_input_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_token_kind,
  input  logic [7:0]        out_text_char,
  input  logic              out_char_valid,
  input  logic              out_token_end,
  input  logic [2:0]        out_error_code,
  output int unsigned       pending_count,
  output int unsigned       mismatch_count
);
  import sexl_pkg::*;

  mode_t       lex_mode;
  logic [7:0]  quoted_char;
  result_t     expected_tokens[$];
  int unsigned errors_seen;

  initial begin
    pending_count  = 0;
    mismatch_count = 0;
    errors_seen    = 0;
    lex_mode       = MODE_IDLE;
    quoted_char    = CH_NUL;
  end

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic opens_symbol(input logic [7:0] c);
    return is_letter(c) || c inside {CH_LT, CH_EQ, CH_GT, CH_UNDER, CH_DOLLAR, CH_PCT, CH_BANG};
  endfunction

  function automatic logic extends_symbol(input logic [7:0] c);
    return is_letter(c) || is_numeral(c) ||
           c inside {CH_AT, CH_MINUS, CH_UNDER, CH_PCT, CH_BANG, CH_COLON};
  endfunction

  task automatic emit(input logic [2:0] kind, input logic [7:0] ch, input logic cvalid,
                      input logic tend, input logic [2:0] err);
    result_t r;
    r.kind   = kind;
    r.text   = ch;
    r.cvalid = cvalid;
    r.tend   = tend;
    r.err    = err;
    expected_tokens = {expected_tokens, r};
  endtask

  // error result, then either an end result (zero byte) or drop until end of text
  task automatic flag_error(input logic [2:0] kind, input logic [7:0] c, input logic [2:0] err);
    emit(kind, c, 1'b0, 1'b1, err);
    if (c == CH_NUL) begin
      emit(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
      lex_mode = MODE_IDLE;
    end else begin
      lex_mode = MODE_DROP;
    end
  endtask

  task automatic start_token(input logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == CH_NUL) begin
      emit(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_LPAREN) begin
      emit(KIND_OPEN, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_RPAREN) begin
      emit(KIND_CLOSE, CH_NUL, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
      // whitespace between tokens
    end else if (c == CH_HASH) begin
      lex_mode = MODE_BOOL;
    end else if (c == CH_DQUOTE) begin
      lex_mode = MODE_STR;
    end else if (c == CH_SQUOTE) begin
      lex_mode = MODE_CHAR1;
    end else if (is_numeral(c) || c == CH_MINUS || c == CH_PLUS) begin
      lex_mode = MODE_INT;
      emit(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
    end else if (opens_symbol(c)) begin
      lex_mode = MODE_SYM;
      emit(KIND_SYMBOL, c, 1'b1, 1'b0, ERR_NONE);
    end else begin
      flag_error(KIND_END, c, ERR_BAD_START);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [7:0] resolved;
    case (lex_mode)
      MODE_BOOL: begin
        if (c == CH_LOW_T || c == CH_LOW_F) begin
          lex_mode = MODE_IDLE;
          emit(KIND_BOOL, c, 1'b1, 1'b1, ERR_NONE);
        end else begin
          flag_error(KIND_BOOL, c, ERR_BAD_BOOL);
        end
      end
      MODE_STR: begin
        if (c == CH_DQUOTE) begin
          lex_mode = MODE_IDLE;
          emit(KIND_STRING, CH_NUL, 1'b0, 1'b1, ERR_NONE);
        end else if (c == CH_NUL) begin
          flag_error(KIND_STRING, c, ERR_OPEN_STR);
        end else if (c == CH_BSLASH) begin
          lex_mode = MODE_ESC;
        end else begin
          emit(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
        end
      end
      MODE_ESC: begin
        case (c)
          CH_BSLASH: resolved = CH_BSLASH;
          CH_DQUOTE: resolved = CH_DQUOTE;
          CH_LOW_N:  resolved = CH_LF;
          CH_LOW_T:  resolved = CH_TAB;
          CH_LOW_R:  resolved = CH_CR;
          default:   resolved = CH_NUL;
        endcase
        if (resolved == CH_NUL) begin
          flag_error(KIND_STRING, c, ERR_BAD_ESCAPE);
        end else begin
          lex_mode = MODE_STR;
          emit(KIND_STRING, resolved, 1'b1, 1'b0, ERR_NONE);
        end
      end
      MODE_CHAR1: begin
        if (c == CH_NUL) begin
          flag_error(KIND_CHAR, c, ERR_BAD_CHAR);
        end else begin
          quoted_char = c;
          lex_mode    = MODE_CHAR2;
        end
      end
      MODE_CHAR2: begin
        if (c == CH_SQUOTE) begin
          lex_mode = MODE_IDLE;
          emit(KIND_CHAR, quoted_char, 1'b1, 1'b1, ERR_NONE);
        end else begin
          flag_error(KIND_CHAR, c, ERR_BAD_CHAR);
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (is_numeral(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
        end else if (c == CH_DOT && lex_mode == MODE_INT) begin
          lex_mode = MODE_FRAC;
          emit(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
        end else begin
          // number closes, the byte is taken again between tokens
          emit(KIND_NUMBER, CH_NUL, 1'b0, 1'b1, ERR_NONE);
          start_token(c);
        end
      end
      MODE_SYM: begin
        if (extends_symbol(c)) begin
          emit(KIND_SYMBOL, c, 1'b1, 1'b0, ERR_NONE);
        end else begin
          emit(KIND_SYMBOL, CH_NUL, 1'b0, 1'b1, ERR_NONE);
          start_token(c);
        end
      end
      MODE_DROP: begin
        if (c == CH_NUL) begin
          lex_mode = MODE_IDLE;
          emit(KIND_END, CH_NUL, 1'b0, 1'b1, ERR_NONE);
        end
      end
      default: start_token(c);
    endcase
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      lex_mode    = MODE_IDLE;
      quoted_char = CH_NUL;
      expected_tokens.delete();
    end else begin
      // compare before predicting: a byte taken at this edge cannot have a result out yet
      if (out_valid && out_ready) begin
        seen.kind   = out_token_kind;
        seen.text   = out_text_char;
        seen.cvalid = out_char_valid;
        seen.tend   = out_token_end;
        seen.err    = out_error_code;
        if (expected_tokens.size() == 0) begin
          if (errors_seen < 10)
            $display("%0t: unexpected word kind %0d text %02h cv %0b end %0b err %0d",
                     $realtime, seen.kind, seen.text, seen.cvalid, seen.tend, seen.err);
          errors_seen++;
        end else begin
          want = expected_tokens.pop_front();
          if (seen !== want) begin
            if (errors_seen < 10)
              $display("%0t: mismatch got k%0d t%02h v%0b e%0b r%0d want k%0d t%02h v%0b e%0b r%0d",
                       $realtime, seen.kind, seen.text, seen.cvalid, seen.tend, seen.err,
                       want.kind, want.text, want.cvalid, want.tend, want.err);
            errors_seen++;
          end
        end
      end
      if (in_valid && in_ready)
        lex_byte(in_input_byte);
    end
    pending_count  <= expected_tokens.size();
    mismatch_count <= errors_seen;
  end

endmodule

// ----- test/testbench.sv -----
// top of the lexer testbench: clock, reset, byte stimulus, result-side stalls and verdict
`timescale 1ns / 100ps

module testbench;
  import sexl_pkg::*;

  // random bytes to send after the directed text
  localparam int unsigned ItemTarget = 1800;
  // watchdog; the slowest legal run is far below this
  localparam int unsigned CycleLimit = 400000;
  // quiet cycles after the last expected word, to catch stray output
  localparam int unsigned DrainCycles = 16;

  // receiver behavior, picked again at random whenever its stretch runs out
  typedef enum logic [1:0] {
    ALWAYS_READY,
    RANDOM_LIGHT,
    PERIODIC,
    RANDOM_HEAVY
  } stall_style_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_input_byte = 8'h00;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_text_char;
  logic        out_char_valid;
  logic        out_token_end;
  logic [2:0]  out_error_code;

  int unsigned pending_count;
  int unsigned mismatch_count;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 1;
  int unsigned cycle_count = 0;

  stall_style_t stall_style = ALWAYS_READY;
  int unsigned  style_left  = 0;
  logic [2:0]   stall_phase = 3'd0;

  s_expression_lexer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_input_byte  (in_input_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_text_char  (out_text_char),
    .out_char_valid (out_char_valid),
    .out_token_end  (out_token_end),
    .out_error_code (out_error_code)
  );

  // watches both channels, predicts every word and counts mismatches
  sexl_token_checker token_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_input_byte  (in_input_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_text_char  (out_text_char),
    .out_char_valid (out_char_valid),
    .out_token_end  (out_token_end),
    .out_error_code (out_error_code),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost word ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: ready pattern switches style now and then, so stalls land on
  // every phase of the lexer's work, with long fully-ready stretches too
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 3'd1;
      if (style_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        style_left  <= $urandom_range(50, 300);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        ALWAYS_READY: out_ready <= 1'b1;
        RANDOM_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        // stalled while the top two phase bits are both set
        PERIODIC:     out_ready <= (stall_phase[2:1] != 2'b11);
        default:      out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // one byte on the input channel; valid stays up across a burst and drops
  // for a random gap between bursts
  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    in_valid      <= 1'b1;
    in_input_byte <= c;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] symbol_head();
    case ($urandom_range(0, 9))
      0:       return CH_LT;
      1:       return CH_EQ;
      2:       return CH_GT;
      3:       return CH_UNDER;
      4:       return CH_DOLLAR;
      5:       return CH_PCT;
      6:       return CH_BANG;
      default: return any_letter();
    endcase
  endfunction

  function automatic logic [7:0] symbol_tail();
    case ($urandom_range(0, 11))
      0:       return CH_AT;
      1:       return CH_MINUS;
      2:       return CH_UNDER;
      3:       return CH_PCT;
      4:       return CH_BANG;
      5:       return CH_COLON;
      6, 7:    return any_digit();
      default: return any_letter();
    endcase
  endfunction

  // one character of string body: escapes, high bytes and plain printables
  task automatic send_string_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: begin
        send_byte(CH_BSLASH);
        case ($urandom_range(0, 4))
          0:       send_byte(CH_BSLASH);
          1:       send_byte(CH_DQUOTE);
          2:       send_byte(CH_LOW_N);
          3:       send_byte(CH_LOW_T);
          default: send_byte(CH_LOW_R);
        endcase
      end
      1: send_byte(8'($urandom_range(128, 255)));
      default: begin
        c = 8'($urandom_range(32, 126));
        if (c == CH_DQUOTE || c == CH_BSLASH) c = "s";
        send_byte(c);
      end
    endcase
  endtask

  // mostly well-formed tokens with random content, plus noise and broken ones
  task automatic send_token();
    case ($urandom_range(0, 19))
      0, 1: send_byte(CH_LPAREN);
      2, 3: send_byte(CH_RPAREN);
      4, 5, 6: begin
        send_byte(symbol_head());
        repeat ($urandom_range(0, 5)) send_byte(symbol_tail());
      end
      7, 8, 9: begin
        // a lone sign is a legal number too
        case ($urandom_range(0, 5))
          0:       send_byte(CH_MINUS);
          1:       send_byte(CH_PLUS);
          default: send_byte(any_digit());
        endcase
        repeat ($urandom_range(0, 4)) send_byte(any_digit());
        if ($urandom_range(0, 1)) begin
          send_byte(CH_DOT);
          repeat ($urandom_range(0, 3)) send_byte(any_digit());
        end
      end
      10, 11: begin
        send_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 6)) send_string_char();
        // occasionally the text ends inside the string
        send_byte(($urandom_range(0, 7) == 0) ? CH_NUL : CH_DQUOTE);
      end
      12: begin
        send_byte(CH_SQUOTE);
        send_byte(8'($urandom_range(1, 255)));
        send_byte(CH_SQUOTE);
      end
      13: begin
        send_byte(CH_HASH);
        send_byte($urandom_range(0, 1) ? CH_LOW_T : CH_LOW_F);
      end
      14, 15: begin
        case ($urandom_range(0, 3))
          0:       send_byte(CH_LF);
          1:       send_byte(CH_CR);
          // tab is not whitespace here and starts an error
          2:       send_byte(CH_TAB);
          default: send_byte(CH_SPACE);
        endcase
      end
      16: send_byte(CH_NUL);
      17: send_byte(8'($urandom_range(0, 255)));
      18: begin
        // broken token, usually followed by end of text so the lexer recovers
        case ($urandom_range(0, 4))
          0: begin
            send_byte(CH_HASH);
            send_byte(8'($urandom_range(0, 255)));
          end
          1: begin
            send_byte(CH_DQUOTE);
            send_byte(CH_BSLASH);
            send_byte(8'($urandom_range(0, 255)));
          end
          2: begin
            send_byte(CH_SQUOTE);
            send_byte(any_letter());
            send_byte(8'($urandom_range(0, 255)));
          end
          3: begin
            send_byte(CH_SQUOTE);
            send_byte(CH_NUL);
          end
          default: send_byte(8'($urandom_range(128, 255)));
        endcase
        if ($urandom_range(0, 3) != 0) send_byte(CH_NUL);
      end
      default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    // directed text: brackets, symbol closed by space, bool, fractional number
    // closed by a bracket, escape then end inside a string, char literal,
    // top byte as bad start then drop to end, bad bool on a letter, and end of
    // text inside a number
    logic [7:0] opening_text [];

    opening_text = '{
      CH_LPAREN, "x", "2", CH_SPACE, CH_HASH, CH_LOW_T, CH_SPACE,
      "1", CH_DOT, "5", CH_RPAREN,
      CH_DQUOTE, CH_BSLASH, CH_LOW_N, CH_NUL,
      CH_SQUOTE, "z", CH_SQUOTE,
      8'hff, CH_NUL,
      CH_HASH, "q", CH_NUL,
      "7", CH_NUL
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_text[i]) send_byte(opening_text[i]);

    bytes_sent = 0;
    while (bytes_sent < ItemTarget) send_token();
    // close whatever token is still open
    send_byte(CH_NUL);
    in_valid <= 1'b0;
    // let the checker count the last byte's words
    @(posedge clk);

    // wait for every predicted word, then watch for strays
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sexl_pkg.sv
hdl/s_expression_lexer_core.sv
hdl/sexl_checker.sv
test/sexl_token_checker.sv
test/testbench.sv
